FILE: src/crc_generate_and_check_assert.svh
`ifndef CRC_GENERATE_AND_CHECK_ASSERT_SVH
`define CRC_GENERATE_AND_CHECK_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define CRCGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define CRCGC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: src/crcgc_pkg.sv
package crcgc_pkg;

  localparam int MaxCheckBits = 16;
  localparam int CntW         = $clog2(MaxCheckBits + 1);
  localparam int GenW         = 17;
  localparam int GenLenW      = 5;
  localparam int CheckW       = 16;
  localparam int AddrW        = 4;
  localparam int DataW        = 32;
  localparam int QueueDepth   = 4;
  localparam int PtrW         = $clog2(QueueDepth);
  localparam int CountW       = $clog2(QueueDepth + 1);

  localparam logic [GenW-1:0]    GenReset    = GenW'(69665);
  localparam logic [GenLenW-1:0] GenLenReset = GenLenW'(17);

  typedef enum logic {
    ModeSender   = 1'b0,
    ModeReceiver = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    RegGenerator = 2'd0,
    RegGenLength = 2'd1,
    RegMode      = 2'd2
  } reg_idx_e;

  typedef struct packed {
    mode_e                   mode;
    logic                    data_bit;
    logic                    last;
    logic [MaxCheckBits-1:0] rem;
    logic [CntW-1:0]         n;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [CntW-1:0] check_bits(logic [GenLenW-1:0] glen);
    int g;
    g = int'(glen);
    if (g < 2) begin
      g = 2;
    end
    if (g - 1 > MaxCheckBits) begin
      g = MaxCheckBits + 1;
    end
    return CntW'(g - 1);
  endfunction

endpackage

FILE: src/crcgc_fifo.sv
`include "crc_generate_and_check_assert.svh"

module crcgc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  crcgc_pkg::job_t   wdata_i,
  input  logic              pop_i,
  output crcgc_pkg::job_t   rdata_o,
  output crcgc_pkg::fifo_stat_t stat_o
);
  import crcgc_pkg::*;

  job_t              mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CountW'(QueueDepth));
  assign stat_o.empty = (count_q == '0);

  `CRCGC_NEVER(fifo_overflow_a, push_i && (count_q == CountW'(QueueDepth)), "queue overflow")
  `CRCGC_NEVER(fifo_underflow_a, pop_i && (count_q == '0), "queue underflow")
  `CRCGC_ASSERT(fifo_count_a, push_i && !pop_i |=> count_q == $past(count_q) + 1'b1, "queue count")

endmodule

FILE: src/crcgc_front.sv
module crcgc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crcgc_pkg::AddrW-1:0]    paddr,
  input  logic [crcgc_pkg::DataW-1:0]    pwdata,
  output logic [crcgc_pkg::DataW-1:0]    prdata,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           data_bit_i,
  input  logic                           frame_end_i,
  input  crcgc_pkg::fifo_stat_t          stat_i,
  output logic                           push_o,
  output crcgc_pkg::job_t                job_o
);
  import crcgc_pkg::*;

  logic [GenW-1:0]         gen_q;
  logic [GenLenW-1:0]      glen_q;
  mode_e                   mode_q;
  logic [MaxCheckBits-1:0] rem_q, rem_d;

  logic [CntW-1:0]         n;
  logic [MaxCheckBits-1:0] mask, msb, gen_m, rem_m, rem_next;
  logic                    top, fb, accept, wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q  <= GenReset;
      glen_q <= GenLenReset;
      mode_q <= ModeSender;
    end else if (wr_en) begin
      case (reg_idx_e'(paddr[3:2]))
        RegGenerator: gen_q  <= pwdata[GenW-1:0];
        RegGenLength: glen_q <= pwdata[GenLenW-1:0];
        RegMode:      mode_q <= mode_e'(pwdata[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      RegGenerator: prdata = DataW'(gen_q);
      RegGenLength: prdata = DataW'(glen_q);
      RegMode:      prdata = DataW'(mode_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    n = check_bits(glen_q);
    for (int i = 0; i < MaxCheckBits; i++) begin
      mask[i] = (i < int'(n));
      msb[i]  = (i == int'(n) - 1);
    end
    gen_m = MaxCheckBits'(gen_q) & mask;
    rem_m = rem_q & mask;
    top   = |(rem_m & msb);
    fb    = data_bit_i ^ top;
    if (mode_q == ModeSender) begin
      rem_next = ((rem_m << 1) & mask) ^ (fb ? gen_m : '0);
    end else begin
      rem_next = (((rem_m << 1) | MaxCheckBits'(data_bit_i)) & mask) ^ (top ? gen_m : '0);
    end
  end

  assign in_stall_o = stat_i.full;
  assign accept     = in_valid_i && !stat_i.full;
  assign push_o     = accept && ((mode_q == ModeSender) || frame_end_i);

  always_comb begin
    rem_d = rem_q;
    if (accept) begin
      rem_d = frame_end_i ? '0 : rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  assign job_o.mode     = mode_q;
  assign job_o.data_bit = data_bit_i;
  assign job_o.last     = frame_end_i;
  assign job_o.rem      = rem_next;
  assign job_o.n        = n;

endmodule

FILE: src/crcgc_back.sv
module crcgc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  crcgc_pkg::job_t                 job_i,
  input  crcgc_pkg::fifo_stat_t           stat_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            code_bit_o,
  output logic [crcgc_pkg::CheckW-1:0]    check_value_o,
  output logic                            mismatch_o,
  output logic                            run_last_o
);
  import crcgc_pkg::*;

  logic                    out_valid_q, out_valid_d;
  logic                    code_q, code_d;
  logic [CheckW-1:0]       check_q, check_d;
  logic                    mis_q, mis_d;
  logic                    last_q, last_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [MaxCheckBits-1:0] sel;
  logic                    load, take;

  assign load = !out_valid_q || !out_stall_i;
  assign take = load && !stat_i.empty;

  always_comb begin
    for (int i = 0; i < MaxCheckBits; i++) begin
      sel[i] = (i == int'(job_i.n) - int'(cnt_q));
    end
  end

  always_comb begin
    pop_o       = 1'b0;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    code_d      = code_q;
    check_d     = check_q;
    mis_d       = mis_q;
    last_d      = last_q;
    if (take) begin
      out_valid_d = 1'b1;
      if (job_i.mode == ModeReceiver) begin
        code_d  = 1'b0;
        check_d = CheckW'(job_i.rem);
        mis_d   = |job_i.rem;
        last_d  = 1'b1;
        pop_o   = 1'b1;
      end else if (cnt_q == '0) begin
        code_d  = job_i.data_bit;
        check_d = '0;
        mis_d   = 1'b0;
        last_d  = 1'b0;
        if (job_i.last) begin
          cnt_d = CntW'(1);
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        code_d  = |(job_i.rem & sel);
        check_d = '0;
        mis_d   = 1'b0;
        last_d  = (cnt_q == job_i.n);
        if (cnt_q == job_i.n) begin
          pop_o = 1'b1;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    check_q <= check_d;
    mis_q   <= mis_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign code_bit_o    = code_q;
  assign check_value_o = check_q;
  assign mismatch_o    = mis_q;
  assign run_last_o    = last_q;

endmodule

FILE: src/crc_generate_and_check.sv
// The first result of a bit passes through the queue and then the output register.
// Input: one bit per cycle unless the queue is full. Output: at most one result per cycle.
// The last bit of a sender frame holds the back end for the bit and then each check bit
// and stays in the four-entry queue, which takes three further bits before the input stalls.
// Reset clears the registers to their defaults, the remainder to zero and the queue to empty.
module crc_generate_and_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [crcgc_pkg::AddrW-1:0]     paddr,
  input  logic [crcgc_pkg::DataW-1:0]     pwdata,
  output logic [crcgc_pkg::DataW-1:0]     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            data_bit_i,
  input  logic                            frame_end_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            code_bit_o,
  output logic [crcgc_pkg::CheckW-1:0]    check_value_o,
  output logic                            mismatch_o,
  output logic                            run_last_o
);
  import crcgc_pkg::*;

  job_t       push_job, head_job;
  fifo_stat_t stat;
  logic       push, pop;

  assign pready = 1'b1;

  crcgc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_bit_i  (data_bit_i),
    .frame_end_i (frame_end_i),
    .stat_i      (stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  crcgc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (head_job),
    .stat_o  (stat)
  );

  crcgc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head_job),
    .stat_i        (stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_bit_o    (code_bit_o),
    .check_value_o (check_value_o),
    .mismatch_o    (mismatch_o),
    .run_last_o    (run_last_o)
  );

endmodule
